// ----- src/sr_l1n_pkg.sv -----
// sr_l1n_pkg: shared types, widths and helpers of the signed root l1 normalizer
// request and result structs, fixed datapath widths, magnitude helper
// no dependencies
`timescale 1ns / 1ps

package sr_l1n_pkg;

	localparam int VAL_W   = 16;
	localparam int MAG_W   = 17;
	localparam int SUM_W   = 22;
	localparam int SCALE_W = 14;
	localparam int PROD_W  = 29;
	localparam int FRAC_SH = 16;
	localparam int NUM_W   = PROD_W + FRAC_SH;
	localparam int QUO_W   = 30;
	localparam int ROOT_W  = 15;
	localparam logic [SCALE_W-1:0] SCALE = SCALE_W'(10000);

	typedef struct packed {
		logic signed [VAL_W-1:0] elem_value;
		logic                    elem_last;
	} elem_t;

	typedef struct packed {
		logic signed [VAL_W-1:0] norm_value;
		logic                    norm_last;
	} norm_t;

	function automatic logic [MAG_W-1:0] mag16(input logic [VAL_W-1:0] v);
		logic [MAG_W-1:0] ext;
		ext = {1'b0, v};
		return v[VAL_W-1] ? (MAG_W'(17'h10000) - ext) : ext;
	endfunction

endpackage

// ----- src/sr_l1n_div.sv -----
// sr_l1n_div: restoring divider, one quotient bit per cycle
// quotient of the scaled magnitude by the l1 total
// depends on sr_l1n_pkg
`timescale 1ns / 1ps

module sr_l1n_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [sr_l1n_pkg::NUM_W-1:0]  num,
	input  logic [sr_l1n_pkg::SUM_W-1:0]  den,
	output logic                          done,
	output logic [sr_l1n_pkg::QUO_W-1:0]  quo
);
	import sr_l1n_pkg::*;

	logic             busy_q;
	logic             done_q;
	logic [5:0]       cnt_q;
	logic [SUM_W-1:0] rem_q;
	logic [SUM_W-1:0] den_q;
	logic [NUM_W-1:0] quo_q;
	logic [SUM_W:0]   trial;
	logic [SUM_W:0]   diff;
	logic             ge;

	assign trial = {rem_q, quo_q[NUM_W-1]};
	assign ge    = trial >= {1'b0, den_q};
	assign diff  = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'(NUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			den_q <= den;
			quo_q <= num;
		end else if (busy_q) begin
			rem_q <= ge ? diff[SUM_W-1:0] : trial[SUM_W-1:0];
			quo_q <= {quo_q[NUM_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quo  = quo_q[QUO_W-1:0];

endmodule

// ----- src/sr_l1n_sqrt.sv -----
// sr_l1n_sqrt: digit by digit integer square root, one root bit per cycle
// truncated root of the quotient
// depends on sr_l1n_pkg
`timescale 1ns / 1ps

module sr_l1n_sqrt (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [sr_l1n_pkg::QUO_W-1:0]  val,
	output logic                          done,
	output logic [sr_l1n_pkg::ROOT_W-1:0] root
);
	import sr_l1n_pkg::*;

	localparam int REM_W = ROOT_W + 2;

	logic              busy_q;
	logic              done_q;
	logic [3:0]        cnt_q;
	logic [QUO_W-1:0]  v_q;
	logic [REM_W-1:0]  rem_q;
	logic [ROOT_W-1:0] root_q;
	logic [REM_W+1:0]  rem_sh;
	logic [REM_W+1:0]  trial;
	logic [REM_W+1:0]  diff;
	logic              ge;

	assign rem_sh = {rem_q, v_q[QUO_W-1:QUO_W-2]};
	assign trial  = {2'b00, root_q, 2'b01};
	assign ge     = rem_sh >= trial;
	assign diff   = rem_sh - trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 4'd1;
				if (cnt_q == 4'(ROOT_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			v_q    <= val;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			v_q    <= {v_q[QUO_W-3:0], 2'b00};
			rem_q  <= ge ? diff[REM_W-1:0] : rem_sh[REM_W-1:0];
			root_q <= {root_q[ROOT_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

// ----- src/signed_root_l1_normalizer_top.sv -----
// signed_root_l1_normalizer_top: loads a vector into an element store, then emits
// sign(x)*100*sqrt(|x|/total) in q8.8 for every stored element in order; depends on sr_l1n_pkg,
// sr_l1n_div, sr_l1n_sqrt. loading: one request per cycle while in load
// emission: one element at a time, each through read, multiply, divide start, 45-step divide plus
// done, root start, 15-step root plus done and output register, and an output stall holds the
// output register; input stalls until the final result is registered; reset clears state
`timescale 1ns / 1ps

module signed_root_l1_normalizer_top #(
	parameter int MAX_LEN = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               elem_valid,
	output logic               elem_stall,
	input  sr_l1n_pkg::elem_t  elem,
	output logic               norm_valid,
	input  logic               norm_stall,
	output sr_l1n_pkg::norm_t  norm
);
	import sr_l1n_pkg::*;

	localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
	localparam int CW = $clog2(MAX_LEN + 1);

	typedef enum logic [2:0] {
		S_LOAD,
		S_READ,
		S_MUL,
		S_DIV,
		S_DWAIT,
		S_SQRT,
		S_SWAIT,
		S_OUT
	} state_t;

	state_t state_q;

	logic [VAL_W-1:0] store_mem [MAX_LEN];
	logic [VAL_W-1:0] rd_data_q;

	logic [CW-1:0]     count_q;
	logic [CW-1:0]     k_q;
	logic [SUM_W-1:0]  sum_q;
	logic [SUM_W-1:0]  total_q;
	logic [PROD_W-1:0] prod_q;
	logic              sign_q;
	logic [ROOT_W-1:0] root_q;
	logic              out_valid_q;
	norm_t             out_q;

	logic              acc;
	logic              room;
	logic [SUM_W-1:0]  sum_next;
	logic              div_done;
	logic [QUO_W-1:0]  quo;
	logic              sqrt_done;
	logic [ROOT_W-1:0] root;
	logic              out_free;
	logic              last_k;
	logic [VAL_W-1:0]  root_ext;

	assign elem_stall = (state_q != S_LOAD);
	assign acc        = elem_valid && !elem_stall;
	assign room       = count_q < CW'(MAX_LEN);
	assign sum_next   = sum_q + SUM_W'(mag16(elem.elem_value));
	assign out_free   = !out_valid_q || !norm_stall;
	assign last_k     = (k_q + CW'(1)) == count_q;
	assign root_ext   = {1'b0, root_q};

	// element store, written only while loading; read every cycle, the read data used only while emitting
	always_ff @(posedge clk) begin
		if (acc && room) begin
			store_mem[count_q[AW-1:0]] <= elem.elem_value;
		end
		rd_data_q <= store_mem[k_q[AW-1:0]];
	end

	sr_l1n_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (state_q == S_DIV),
		.num    ({prod_q, FRAC_SH'(0)}),
		.den    (total_q),
		.done   (div_done),
		.quo    (quo)
	);

	sr_l1n_sqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (state_q == S_SQRT),
		.val    (quo),
		.done   (sqrt_done),
		.root   (root)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_LOAD;
			count_q     <= '0;
			k_q         <= '0;
			sum_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == S_OUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!norm_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_LOAD: begin
					if (acc) begin
						if (room) begin
							count_q <= count_q + CW'(1);
							sum_q   <= sum_next;
						end
						if (elem.elem_last) begin
							k_q     <= '0;
							state_q <= S_READ;
						end
					end
				end
				S_READ:  state_q <= S_MUL;
				S_MUL:   state_q <= S_DIV;
				S_DIV:   state_q <= S_DWAIT;
				S_DWAIT: if (div_done) state_q <= S_SQRT;
				S_SQRT:  state_q <= S_SWAIT;
				S_SWAIT: if (sqrt_done) state_q <= S_OUT;
				S_OUT: begin
					if (out_free) begin
						if (last_k) begin
							count_q <= '0;
							sum_q   <= '0;
							state_q <= S_LOAD;
						end else begin
							k_q     <= k_q + CW'(1);
							state_q <= S_READ;
						end
					end
				end
				default: state_q <= S_LOAD;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (acc && elem.elem_last) begin
			if (room) begin
				total_q <= (sum_next == '0) ? SUM_W'(1) : sum_next;
			end else begin
				total_q <= (sum_q == '0) ? SUM_W'(1) : sum_q;
			end
		end
		if (state_q == S_MUL) begin
			prod_q <= PROD_W'(mag16(rd_data_q)) * PROD_W'(SCALE);
			sign_q <= rd_data_q[VAL_W-1];
		end
		if (sqrt_done) begin
			root_q <= root;
		end
		if (state_q == S_OUT && out_free) begin
			out_q.norm_value <= sign_q ? (VAL_W'(0) - root_ext) : root_ext;
			out_q.norm_last  <= last_k;
		end
	end

	assign norm_valid = out_valid_q;
	assign norm       = out_q;

endmodule

// ----- src/sr_l1n_checker.sv -----
// sr_l1n_checker: port level checks of the normalizer top
// bound to signed_root_l1_normalizer_top
// depends on sr_l1n_pkg
`timescale 1ns / 1ps

module sr_l1n_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              elem_valid,
	input logic              elem_stall,
	input sr_l1n_pkg::elem_t elem,
	input logic              norm_valid,
	input logic              norm_stall,
	input sr_l1n_pkg::norm_t norm
);
	import sr_l1n_pkg::*;

	logic in_last_acc;

	assign in_last_acc = elem_valid && !elem_stall && elem.elem_last;

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		norm_valid && norm_stall |=> norm_valid && $stable(norm))
		else $error("stalled result changed");

	// a last request starts emission and blocks input
	a_last_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_last_acc |=> elem_stall)
		else $error("input open after last request");

	// loading reopens only together with the final result of a vector
	a_reopen: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(elem_stall) |-> norm_valid && norm.norm_last)
		else $error("input reopened without final result");

	// magnitude is bounded by 100 in q8.8
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		norm_valid |-> ($signed(norm.norm_value) <= 16'sd25600) &&
			($signed(norm.norm_value) >= -16'sd25600))
		else $error("result out of range");

endmodule

bind signed_root_l1_normalizer_top sr_l1n_checker u_sr_l1n_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.elem_valid (elem_valid),
	.elem_stall (elem_stall),
	.elem       (elem),
	.norm_valid (norm_valid),
	.norm_stall (norm_stall),
	.norm       (norm)
);

// ----- bench/signed_root_l1_normalizer_top_tb.sv -----
// signed_root_l1_normalizer_top_tb: self-checking bench for the signed root l1 normalizer
// drives element requests with random gaps, predicts normalized vectors, checks outputs
// depends on sr_l1n_pkg and signed_root_l1_normalizer_top
`timescale 1ns / 1ps

module signed_root_l1_normalizer_top_tb;

	import sr_l1n_pkg::*;

	localparam int VEC_CAP = 64;
	localparam int STALL_LIMIT = 20000;

	class norm_scoreboard;
		logic [15:0] held_elems[$];
		logic [21:0] l1_total;
		norm_t pending_norms[$];
		int errors;

		function new();
			l1_total = '0;
			errors = 0;
		endfunction

		function logic [16:0] magnitude(logic [15:0] v);
			return v[15] ? 17'h10000 - {1'b0, v} : {1'b0, v};
		endfunction

		function logic [63:0] root64(logic [63:0] v);
			logic [63:0] r;
			logic [63:0] b;
			r = 0;
			b = 64'd1 << 62;
			while (b > v) b >>= 2;
			while (b != 0) begin
				if (v >= r + b) begin
					v -= r + b;
					r = (r >> 1) + b;
				end else begin
					r >>= 1;
				end
				b >>= 2;
			end
			return r;
		endfunction

		function void note_request(elem_t e);
			logic [63:0] tot;
			logic [63:0] q;
			logic [63:0] r;
			norm_t n;
			if (held_elems.size() < VEC_CAP) begin
				held_elems = {held_elems, e.elem_value};
				l1_total = l1_total + 22'(magnitude(e.elem_value));
			end
			if (!e.elem_last) return;
			tot = (l1_total == 0) ? 64'd1 : 64'(l1_total);
			foreach (held_elems[k]) begin
				q = (64'(magnitude(held_elems[k])) * 64'd10000 * 64'd65536) / tot;
				r = root64(q);
				n.norm_value = held_elems[k][15] ? 16'(17'h10000 - r[16:0]) : r[15:0];
				n.norm_last = (k == held_elems.size() - 1);
				pending_norms = {pending_norms, n};
			end
			held_elems.delete();
			l1_total = '0;
		endfunction

		function void check_result(norm_t got);
			norm_t exp_n;
			if (pending_norms.size() == 0) begin
				$error("unexpected result norm_value=%0d", got.norm_value);
				errors++;
				return;
			end
			exp_n = pending_norms.pop_front();
			if (got.norm_value !== exp_n.norm_value) begin
				$error("norm_value expected %0d actual %0d", exp_n.norm_value, got.norm_value);
				errors++;
			end
			if (got.norm_last !== exp_n.norm_last) begin
				$error("norm_last expected %0d actual %0d", exp_n.norm_last, got.norm_last);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic elem_valid;
	logic elem_stall;
	elem_t elem;
	logic norm_valid;
	logic norm_stall;
	norm_t norm;

	norm_scoreboard sb;
	bit quiet_mode;
	bit hold_off_req;
	int idle_cycles;

	signed_root_l1_normalizer_top DUT (
		.clk(clk), .arst_n(arst_n),
		.elem_valid(elem_valid), .elem_stall(elem_stall), .elem(elem),
		.norm_valid(norm_valid), .norm_stall(norm_stall), .norm(norm)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial sb = new();

	// accepted requests and results, sampled at the rising edge; an idle timeout ends the run with FAIL
	always @(posedge clk) begin
		if (arst_n) begin
			if (elem_valid && !elem_stall) begin
				sb.note_request(elem);
			end
			if (norm_valid && !norm_stall) begin
				sb.check_result(norm);
			end
			if ((elem_valid && !elem_stall) || (norm_valid && !norm_stall)) begin
				idle_cycles <= 0;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
			if (idle_cycles > STALL_LIMIT) begin
				$display("FAIL signed_root_l1_normalizer_top");
				$finish;
			end
		end else begin
			idle_cycles <= 0;
		end
	end

	// receiver stall bursts
	initial begin
		norm_stall = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_off_req) begin
				norm_stall <= 1;
				repeat (1500) @(negedge clk);
				hold_off_req = 0;
				norm_stall <= 0;
			end else if (!quiet_mode && $urandom_range(0, 7) == 0) begin
				norm_stall <= 1;
				repeat ($urandom_range(1, 16)) @(negedge clk);
				norm_stall <= 0;
			end
		end
	end

	task automatic send_elem(logic [15:0] v, logic l);
		if (!quiet_mode && $urandom_range(0, 7) == 0) begin
			elem_valid <= 0;
			repeat ($urandom_range(1, 16)) @(negedge clk);
		end
		elem_valid <= 1;
		elem.elem_value <= v;
		elem.elem_last <= l;
		@(posedge clk);
		while (elem_stall) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic send_vector(int len, int kind);
		logic [15:0] v;
		for (int i = 0; i < len; i++) begin
			case (kind)
				0: v = 16'($urandom);
				1: v = 16'($urandom_range(0, 255)) ^ ($urandom_range(0, 1) ? 16'hFFFF : 16'h0);
				2: v = 16'h0;
				default: v = ($urandom_range(0, 1)) ? 16'h8000 : 16'h7FFF;
			endcase
			send_elem(v, i == len - 1);
		end
	endtask

	task automatic wait_drained();
		elem_valid <= 0;
		while (sb.pending_norms.size() != 0) @(negedge clk);
	endtask

	initial begin
		int len;
		arst_n = 0;
		elem_valid = 0;
		elem = '0;
		quiet_mode = 0;
		hold_off_req = 0;
		repeat (10) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// directed: extremes, zero vector, single element, sign mix, overfull store
		send_elem(16'h8000, 1);
		send_elem(16'h7FFF, 1);
		send_elem(16'h0000, 1);
		send_elem(16'h0000, 0);
		send_elem(16'h0000, 1);
		send_elem(16'h8000, 0);
		send_elem(16'h7FFF, 0);
		send_elem(16'h0001, 0);
		send_elem(16'hFFFF, 0);
		send_elem(16'h0000, 1);
		wait_drained();
		send_vector(66, 3);
		wait_drained();

		// long receiver hold-off while the sender keeps offering
		hold_off_req = 1;
		send_vector(8, 0);
		send_vector(6, 1);
		wait_drained();

		for (int n = 0; n < 24; n++) begin
			if (n == 20) quiet_mode = 1;
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 66) : $urandom_range(1, 8);
			send_vector(len, $urandom_range(0, 9) == 0 ? 2 : $urandom_range(0, 1));
			if (n == 10) wait_drained();
		end

		wait_drained();
		repeat (200) @(negedge clk);
		if (sb.errors == 0 && sb.pending_norms.size() == 0) begin
			$display("PASS signed_root_l1_normalizer_top");
		end else begin
			$display("FAIL signed_root_l1_normalizer_top");
		end
		$finish;
	end

endmodule

// ----- filelist.f -----
src/sr_l1n_pkg.sv
src/sr_l1n_div.sv
src/sr_l1n_sqrt.sv
src/signed_root_l1_normalizer_top.sv
src/sr_l1n_checker.sv
bench/signed_root_l1_normalizer_top_tb.sv
